@@ hw/rtl/bsq_pkg.sv @@
// ----------------------------------------------------------------------------
// Batched SPSC ring queue package
// Sizes, codes, payload types and index helpers shared by the queue's files.
// ----------------------------------------------------------------------------
package bsq_pkg;

  localparam int unsigned SLOTS       = 1024;
  localparam int unsigned BATCH       = 16;
  localparam int unsigned TUPLE_BYTES = 8;

  localparam int unsigned DATA_W = 64;
  localparam int unsigned LEN_W  = 4;
  localparam int unsigned OCC_W  = 10;
  localparam int unsigned IDX_W  = $clog2(SLOTS);
  localparam int unsigned BCNT_W = $clog2(BATCH + 1);

  typedef logic [IDX_W-1:0]  idx_t;
  typedef logic [BCNT_W-1:0] bcnt_t;

  typedef enum logic [1:0] {
    MODE_WRITE     = 2'd0,
    MODE_READ      = 2'd1,
    MODE_FLUSH     = 2'd2,
    MODE_READ_DONE = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    STATUS_OK    = 2'd0,
    STATUS_FULL  = 2'd1,
    STATUS_EMPTY = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WRITE,
    ST_READ
  } state_e;

  typedef struct packed {
    mode_e             mode;
    logic [DATA_W-1:0] write_data;
    logic [LEN_W-1:0]  write_len;
  } in_t;

  typedef struct packed {
    status_e           status;
    logic [DATA_W-1:0] read_data;
    logic [OCC_W-1:0]  occupancy;
  } out_t;

  function automatic idx_t adv_idx(idx_t idx);
    idx_t res;
    if (idx == idx_t'(SLOTS - 1)) begin
      res = '0;
    end else begin
      res = idx + idx_t'(1);
    end
    return res;
  endfunction

  function automatic logic [OCC_W-1:0] occ_calc(idx_t pn, idx_t pcr);
    logic [IDX_W:0] diff;
    diff = {1'b0, pn} - {1'b0, pcr};
    if (pn < pcr) begin
      diff = diff + (IDX_W + 1)'(SLOTS);
    end
    return OCC_W'(diff);
  endfunction

  function automatic logic [DATA_W-1:0] byte_mask(logic [LEN_W-1:0] nbytes);
    logic [DATA_W-1:0] m;
    m = '0;
    for (int b = 0; b < TUPLE_BYTES; b++) begin
      if (LEN_W'(b) < nbytes) begin
        m[8*b +: 8] = 8'hFF;
      end
    end
    return m;
  endfunction

endpackage

@@ hw/rtl/bsq_ram.sv @@
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port, read data registered on a read enable.
// ----------------------------------------------------------------------------
module bsq_ram #(
  parameter int unsigned Width = 64,
  parameter int unsigned Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ hw/rtl/batched_spsc_ring_queue_top.sv @@
// ----------------------------------------------------------------------------
// Batched SPSC ring queue
// Ring of tuple slots with private and published producer/consumer indices.
//
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+-----------------------------
//   in      | input     | in_valid_i/in_ready_o | in_i  (mode, data, length)
//   out     | output    | out_valid_o/out_ready_i | out_o (status, data, occ.)
//
// Flush, read-complete and refused items are answered straight from the idle
// state; a successful write or read first passes through a write or read state,
// since the slot memory, whose read data is registered, is read first (merge or fetch).
// Reset clears all indices and counts at once; slots never written read as
// zero through the producer's wrap flag, so no clearing pass is needed.
// A new item is taken once the queue is idle and the result register is free or being emptied.
// ----------------------------------------------------------------------------
module batched_spsc_ring_queue_top (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  bsq_pkg::in_t  in_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output bsq_pkg::out_t out_o
);

  bsq_pkg::state_e state_q, state_d;

  bsq_pkg::idx_t  pn_q, pn_d;
  bsq_pkg::idx_t  pcr_q, pcr_d;
  bsq_pkg::idx_t  cn_q, cn_d;
  bsq_pkg::idx_t  ccw_q, ccw_d;
  bsq_pkg::idx_t  pwi_q, pwi_d;
  bsq_pkg::idx_t  pri_q, pri_d;
  bsq_pkg::bcnt_t wcnt_q, wcnt_d;
  bsq_pkg::bcnt_t rcnt_q, rcnt_d;
  logic           wrapped_q, wrapped_d;

  bsq_pkg::out_t               pend_q, pend_d;
  logic [bsq_pkg::DATA_W-1:0]  wdata_q, wdata_d;
  logic [bsq_pkg::DATA_W-1:0]  wmask_q, wmask_d;
  logic                        fresh_q, fresh_d;
  bsq_pkg::idx_t               slot_q, slot_d;

  bsq_pkg::out_t out_q, out_d;
  logic          out_valid_q, out_valid_d;

  logic                       fire;
  logic                       out_free;
  logic                       wr_ok;
  logic                       rd_ok;
  bsq_pkg::idx_t              after;
  bsq_pkg::status_e           status;
  logic [bsq_pkg::LEN_W-1:0]  clen;

  logic                       ram_we;
  logic                       ram_re;
  bsq_pkg::idx_t              ram_raddr;
  logic [bsq_pkg::DATA_W-1:0] ram_wdata;
  logic [bsq_pkg::DATA_W-1:0] ram_rdata;
  logic [bsq_pkg::DATA_W-1:0] old_data;

  localparam logic [bsq_pkg::DATA_W-1:0] TupleMask =
    bsq_pkg::byte_mask(bsq_pkg::LEN_W'(bsq_pkg::TUPLE_BYTES));

  assign out_free   = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == bsq_pkg::ST_IDLE) && out_free;
  assign fire       = in_valid_i && in_ready_o;

  // Index bookkeeping, done when an item is taken.
  always_comb begin
    pn_d      = pn_q;
    pcr_d     = pcr_q;
    cn_d      = cn_q;
    ccw_d     = ccw_q;
    pwi_d     = pwi_q;
    pri_d     = pri_q;
    wcnt_d    = wcnt_q;
    rcnt_d    = rcnt_q;
    wrapped_d = wrapped_q;
    wr_ok     = 1'b0;
    rd_ok     = 1'b0;
    status    = bsq_pkg::STATUS_OK;
    after     = bsq_pkg::adv_idx(pn_q);
    if (fire) begin
      case (in_i.mode)
        bsq_pkg::MODE_WRITE: begin
          if ((after == pcr_q) && (after == pri_q)) begin
            status = bsq_pkg::STATUS_FULL;
          end else begin
            if (after == pcr_q) begin
              pcr_d = pri_q;
            end
            wr_ok     = 1'b1;
            pn_d      = after;
            wrapped_d = wrapped_q || (after == '0);
            if ((wcnt_q + bsq_pkg::BCNT_W'(1)) >= bsq_pkg::BCNT_W'(bsq_pkg::BATCH)) begin
              pwi_d  = after;
              wcnt_d = '0;
            end else begin
              wcnt_d = wcnt_q + bsq_pkg::BCNT_W'(1);
            end
          end
        end
        bsq_pkg::MODE_READ: begin
          if ((cn_q == ccw_q) && (cn_q == pwi_q)) begin
            status = bsq_pkg::STATUS_EMPTY;
          end else begin
            if (cn_q == ccw_q) begin
              ccw_d = pwi_q;
            end
            rd_ok = 1'b1;
            cn_d  = bsq_pkg::adv_idx(cn_q);
            if ((rcnt_q + bsq_pkg::BCNT_W'(1)) >= bsq_pkg::BCNT_W'(bsq_pkg::BATCH)) begin
              pri_d  = bsq_pkg::adv_idx(cn_q);
              rcnt_d = '0;
            end else begin
              rcnt_d = rcnt_q + bsq_pkg::BCNT_W'(1);
            end
          end
        end
        bsq_pkg::MODE_FLUSH: begin
          pwi_d = pn_q;
          pri_d = cn_q;
        end
        bsq_pkg::MODE_READ_DONE: begin
          pri_d = cn_q;
          pcr_d = cn_q;
        end
        default: begin
        end
      endcase
    end
  end

  // Pending result and write operands for the memory step.
  always_comb begin
    clen = (in_i.write_len > bsq_pkg::LEN_W'(bsq_pkg::TUPLE_BYTES)) ?
           bsq_pkg::LEN_W'(bsq_pkg::TUPLE_BYTES) : in_i.write_len;
    pend_d           = pend_q;
    wdata_d          = wdata_q;
    wmask_d          = wmask_q;
    fresh_d          = fresh_q;
    slot_d           = slot_q;
    if (fire) begin
      pend_d.status    = status;
      pend_d.read_data = '0;
      pend_d.occupancy = bsq_pkg::occ_calc(pn_d, pcr_d);
      wdata_d          = in_i.write_data;
      wmask_d          = bsq_pkg::byte_mask(clen);
      fresh_d          = !wrapped_q;
      slot_d           = pn_q;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      bsq_pkg::ST_IDLE: begin
        if (wr_ok) begin
          state_d = bsq_pkg::ST_WRITE;
        end else if (rd_ok) begin
          state_d = bsq_pkg::ST_READ;
        end
      end
      bsq_pkg::ST_WRITE, bsq_pkg::ST_READ: begin
        if (out_free) begin
          state_d = bsq_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = bsq_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    ram_re      = wr_ok || rd_ok;
    ram_raddr   = wr_ok ? pn_q : cn_q;
    old_data    = fresh_q ? '0 : ram_rdata;
    ram_wdata   = (old_data & ~wmask_q) | (wdata_q & wmask_q);
    ram_we      = 1'b0;
    out_d       = out_q;
    out_valid_d = out_valid_q && !out_ready_i;
    case (state_q)
      bsq_pkg::ST_IDLE: begin
        if (fire && !wr_ok && !rd_ok) begin
          out_d       = pend_d;
          out_valid_d = 1'b1;
        end
      end
      bsq_pkg::ST_WRITE: begin
        if (out_free) begin
          ram_we      = 1'b1;
          out_d       = pend_q;
          out_valid_d = 1'b1;
        end
      end
      bsq_pkg::ST_READ: begin
        if (out_free) begin
          out_d           = pend_q;
          out_d.read_data = ram_rdata & TupleMask;
          out_valid_d     = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  bsq_ram #(
    .Width (bsq_pkg::DATA_W),
    .Depth (bsq_pkg::SLOTS)
  ) u_slot_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (slot_q),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= bsq_pkg::ST_IDLE;
      pn_q        <= '0;
      pcr_q       <= '0;
      cn_q        <= '0;
      ccw_q       <= '0;
      pwi_q       <= '0;
      pri_q       <= '0;
      wcnt_q      <= '0;
      rcnt_q      <= '0;
      wrapped_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      pn_q        <= pn_d;
      pcr_q       <= pcr_d;
      cn_q        <= cn_d;
      ccw_q       <= ccw_d;
      pwi_q       <= pwi_d;
      pri_q       <= pri_d;
      wcnt_q      <= wcnt_d;
      rcnt_q      <= rcnt_d;
      wrapped_q   <= wrapped_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_q  <= pend_d;
    wdata_q <= wdata_d;
    wmask_q <= wmask_d;
    fresh_q <= fresh_d;
    slot_q  <= slot_d;
    out_q   <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

endmodule

@@ test/batched_spsc_ring_queue_top_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Batched SPSC ring queue testbench
// Drives write, read, flush and read-complete items into the queue, predicts
// status, read data and occupancy from a private copy of the ring state, and
// compares every result in order while the channels idle at random by phase.
// ----------------------------------------------------------------------------
module batched_spsc_ring_queue_top_tb;

  localparam int unsigned RANDOM_ITEMS = 1400;
  localparam int unsigned PHASES       = 4;

  class queue_scoreboard;
    logic [bsq_pkg::DATA_W-1:0] slot_mem [bsq_pkg::SLOTS];
    int unsigned pub_rd;
    int unsigned pub_wr;
    int unsigned prod_next;
    int unsigned prod_cached_rd;
    int unsigned cons_next;
    int unsigned cons_cached_wr;
    int unsigned wr_batch;
    int unsigned rd_batch;
    bsq_pkg::out_t expected_q [$];
    int unsigned mismatches;
    int unsigned full_refusals;
    int unsigned empty_refusals;

    function new();
      foreach (slot_mem[i]) begin
        slot_mem[i] = '0;
      end
    endfunction

    function int unsigned next_index(int unsigned idx);
      return (idx + 1) % bsq_pkg::SLOTS;
    endfunction

    function logic [bsq_pkg::DATA_W-1:0] keep_mask(int unsigned nbytes);
      if (nbytes >= 8) begin
        return '1;
      end
      return (bsq_pkg::DATA_W'(1) << (8 * nbytes)) - bsq_pkg::DATA_W'(1);
    endfunction

    function int unsigned queued();
      return (prod_next + bsq_pkg::SLOTS - cons_next) % bsq_pkg::SLOTS;
    endfunction

    function void note_item(bsq_pkg::in_t it);
      bsq_pkg::out_t exp_r;
      int unsigned after;
      int unsigned len;
      logic [bsq_pkg::DATA_W-1:0] m;
      logic ok;
      exp_r = '0;
      exp_r.status = bsq_pkg::STATUS_OK;
      case (it.mode)
        bsq_pkg::MODE_WRITE: begin
          ok = 1'b1;
          after = next_index(prod_next);
          if (after == prod_cached_rd) begin
            if (after == pub_rd) begin
              ok = 1'b0;
            end else begin
              prod_cached_rd = pub_rd;
            end
          end
          if (ok) begin
            len = (it.write_len > bsq_pkg::TUPLE_BYTES) ?
                  bsq_pkg::TUPLE_BYTES : it.write_len;
            m = keep_mask(len);
            slot_mem[prod_next] = (slot_mem[prod_next] & ~m) | (it.write_data & m);
            prod_next = after;
            wr_batch++;
            if (wr_batch >= bsq_pkg::BATCH) begin
              pub_wr = prod_next;
              wr_batch = 0;
            end
          end else begin
            exp_r.status = bsq_pkg::STATUS_FULL;
            full_refusals++;
          end
        end
        bsq_pkg::MODE_READ: begin
          ok = 1'b1;
          if (cons_next == cons_cached_wr) begin
            if (cons_next == pub_wr) begin
              ok = 1'b0;
            end else begin
              cons_cached_wr = pub_wr;
            end
          end
          if (ok) begin
            exp_r.read_data = slot_mem[cons_next] & keep_mask(bsq_pkg::TUPLE_BYTES);
            cons_next = next_index(cons_next);
            rd_batch++;
            if (rd_batch >= bsq_pkg::BATCH) begin
              pub_rd = cons_next;
              rd_batch = 0;
            end
          end else begin
            exp_r.status = bsq_pkg::STATUS_EMPTY;
            empty_refusals++;
          end
        end
        bsq_pkg::MODE_FLUSH: begin
          pub_wr = prod_next;
          pub_rd = cons_next;
        end
        default: begin
          pub_rd = cons_next;
          prod_cached_rd = cons_next;
        end
      endcase
      exp_r.occupancy = bsq_pkg::OCC_W'(
        (prod_next + bsq_pkg::SLOTS - prod_cached_rd) % bsq_pkg::SLOTS);
      expected_q.push_back(exp_r);
    endfunction

    task report(string what, logic [bsq_pkg::DATA_W-1:0] exp_v,
                logic [bsq_pkg::DATA_W-1:0] got_v);
      $display("ERROR: %s mismatch, expected %h, got %h", what, exp_v, got_v);
      mismatches++;
    endtask

    task check_result(bsq_pkg::out_t got);
      bsq_pkg::out_t exp_r;
      if (expected_q.size() == 0) begin
        report("unexpected result", '0, got.read_data);
      end else begin
        exp_r = expected_q.pop_front();
        if (got.status !== exp_r.status) begin
          report("status", exp_r.status, got.status);
        end
        if (got.read_data !== exp_r.read_data) begin
          report("read_data", exp_r.read_data, got.read_data);
        end
        if (got.occupancy !== exp_r.occupancy) begin
          report("occupancy", exp_r.occupancy, got.occupancy);
        end
      end
    endtask
  endclass

  logic          clk_i       = 1'b0;
  logic          rst_ni      = 1'b0;
  logic          in_valid_i  = 1'b0;
  logic          in_ready_o;
  bsq_pkg::in_t  in_i        = '0;
  logic          out_valid_o;
  logic          out_ready_i = 1'b0;
  bsq_pkg::out_t out_o;

  queue_scoreboard sb;
  int unsigned rx_stall_pct = 0;
  int unsigned tx_pct [PHASES] = '{0, 55, 0, 20};
  int unsigned rx_pct [PHASES] = '{0, 0, 55, 20};

  batched_spsc_ring_queue_top dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_i        (in_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_o       (out_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  function automatic bsq_pkg::in_t make_item(bsq_pkg::mode_e mode,
                                             logic [bsq_pkg::DATA_W-1:0] data,
                                             logic [bsq_pkg::LEN_W-1:0] len);
    bsq_pkg::in_t it;
    it.mode = mode;
    it.write_data = data;
    it.write_len = len;
    return it;
  endfunction

  function automatic bsq_pkg::in_t pick_item(logic filling);
    bsq_pkg::in_t it;
    int unsigned roll;
    it.write_data = {$urandom, $urandom};
    it.write_len = bsq_pkg::LEN_W'($urandom_range(15));
    roll = $urandom_range(99);
    if (roll < 93) begin
      it.mode = filling ? bsq_pkg::MODE_WRITE : bsq_pkg::MODE_READ;
    end else if (roll < 97) begin
      it.mode = filling ? bsq_pkg::MODE_READ : bsq_pkg::MODE_WRITE;
    end else if (roll < 99) begin
      it.mode = bsq_pkg::MODE_FLUSH;
    end else begin
      it.mode = bsq_pkg::MODE_READ_DONE;
    end
    return it;
  endfunction

  task automatic send_item(bsq_pkg::in_t it, int unsigned idle_pct);
    int unsigned gap;
    gap = 0;
    while ($urandom_range(99) < idle_pct && gap < 40) begin
      gap++;
    end
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_i <= it;
    @(posedge clk_i);
    while (!in_ready_o) begin
      @(posedge clk_i);
    end
    sb.note_item(it);
  endtask

  always @(posedge clk_i) begin
    if (out_valid_o && out_ready_i) begin
      sb.check_result(out_o);
    end
    out_ready_i <= ($urandom_range(99) >= rx_stall_pct);
  end

  initial begin
    #2_000_000;
    $display("simulation failed");
    $finish;
  end

  initial begin : stimulus
    int unsigned phase;
    int unsigned n;
    logic filling;
    sb = new();
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    rx_stall_pct = 20;
    send_item(make_item(bsq_pkg::MODE_READ, '0, 4'd0), 20);
    send_item(make_item(bsq_pkg::MODE_FLUSH, '1, 4'd15), 20);
    send_item(make_item(bsq_pkg::MODE_READ_DONE, '0, 4'd0), 20);
    send_item(make_item(bsq_pkg::MODE_WRITE, 64'hFFFF_FFFF_FFFF_FFFF, 4'd0), 20);
    send_item(make_item(bsq_pkg::MODE_WRITE, 64'hFFFF_FFFF_FFFF_FFFF, 4'd8), 20);
    send_item(make_item(bsq_pkg::MODE_WRITE, 64'h0123_4567_89AB_CDEF, 4'd3), 20);
    send_item(make_item(bsq_pkg::MODE_WRITE, 64'h0, 4'd15), 20);
    send_item(make_item(bsq_pkg::MODE_WRITE, 64'hA5A5_A5A5_A5A5_A5A5, 4'd1), 20);
    send_item(make_item(bsq_pkg::MODE_READ, '0, 4'd0), 20);
    send_item(make_item(bsq_pkg::MODE_FLUSH, '0, 4'd0), 20);
    repeat (4) send_item(make_item(bsq_pkg::MODE_READ, '1, 4'd15), 20);
    send_item(make_item(bsq_pkg::MODE_READ, '0, 4'd0), 20);
    send_item(make_item(bsq_pkg::MODE_READ_DONE, '1, 4'd15), 20);
    send_item(make_item(bsq_pkg::MODE_WRITE, 64'h5555_5555_5555_5555, 4'd7), 20);
    send_item(make_item(bsq_pkg::MODE_WRITE, 64'hFFFF_FFFF_FFFF_FFFF, 4'd2), 20);
    send_item(make_item(bsq_pkg::MODE_WRITE, 64'h0, 4'd8), 20);
    send_item(make_item(bsq_pkg::MODE_FLUSH, '0, 4'd0), 20);
    repeat (3) send_item(make_item(bsq_pkg::MODE_READ, '0, 4'd0), 20);

    filling = 1'b1;
    sb.full_refusals = 0;
    sb.empty_refusals = 0;
    for (phase = 0; phase < PHASES; phase++) begin
      rx_stall_pct = rx_pct[phase];
      for (n = 0; n < RANDOM_ITEMS / PHASES; n++) begin
        send_item(pick_item(filling), tx_pct[phase]);
        if (filling && sb.full_refusals >= 4) begin
          filling = 1'b0;
          sb.full_refusals = 0;
          sb.empty_refusals = 0;
        end else if (!filling && (sb.queued() < 800 || sb.empty_refusals >= 3)) begin
          filling = 1'b1;
          sb.full_refusals = 0;
          sb.empty_refusals = 0;
        end
      end
    end
    in_valid_i <= 1'b0;

    while (sb.expected_q.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (20) @(posedge clk_i);
    if (sb.mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
hw/rtl/bsq_pkg.sv
hw/rtl/bsq_ram.sv
hw/rtl/batched_spsc_ring_queue_top.sv
test/batched_spsc_ring_queue_top_tb.sv
